### hw/rtl/shtok_pkg.sv
// shared types, codes and constants of the syslog header tokenizer
`default_nettype none
package shtok_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_LT      = 4'd0,
    PH_PRI     = 4'd1,
    PH_VER     = 4'd2,
    PH_VERTAIL = 4'd3,
    PH_HDR     = 4'd4,
    PH_SDSTART = 4'd5,
    PH_SD      = 4'd6,
    PH_SDAFTER = 4'd7,
    PH_TS      = 4'd8,
    PH_HOST    = 4'd9,
    PH_MSG     = 4'd10,
    PH_ERR     = 4'd11
  } phase_e;

  // field tag of one byte
  typedef enum logic [3:0] {
    K_PRI    = 4'd0,
    K_VER    = 4'd1,
    K_SEP    = 4'd2,
    K_TS     = 4'd3,
    K_HOST   = 4'd4,
    K_APP    = 4'd5,
    K_PROCID = 4'd6,
    K_MSGID  = 4'd7,
    K_SD     = 4'd8,
    K_MSG    = 4'd9
  } field_kind_e;

  // sticky error codes
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_LT   = 2'd1,
    ERR_BAD_PRI = 2'd2,
    ERR_TRUNC   = 2'd3
  } err_e;

  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLbr    = 8'h5B;
  localparam logic [7:0] ChRbr    = 8'h5D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChOne    = 8'h31;

  localparam logic [10:0] PriMax    = 11'd191;
  localparam logic [1:0]  PriDigMax = 2'd3;
  localparam logic [2:0]  TsTokens  = 3'd3;
  localparam logic [2:0]  HdrTokens = 3'd5;
  localparam logic [2:0]  KindClamp = 3'd4;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] pri_accum;
    logic [1:0] pri_digits;
    logic [2:0] token_count;
    logic       escape_seen;
    logic       inside_sd_element;
    err_e       sticky_error;
    logic [7:0] held_priority;
    logic       format_flag;
  } state_t;

  localparam state_t StateReset = '{
    phase:             PH_LT,
    pri_accum:         8'd0,
    pri_digits:        2'd0,
    token_count:       3'd0,
    escape_seen:       1'b0,
    inside_sd_element: 1'b0,
    sticky_error:      ERR_NONE,
    held_priority:     8'd0,
    format_flag:       1'b0
  };

  // one registered input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } stage_t;

  // one result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] field_kind;
    logic [4:0] facility;
    logic [2:0] severity;
    logic       pri_valid;
    logic       modern_format;
    logic [1:0] error_code;
    logic       line_end;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/shtok_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface shtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface shtok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [3:0] field_kind;
  logic [4:0] facility;
  logic [2:0] severity;
  logic       pri_valid;
  logic       modern_format;
  logic [1:0] error_code;
  logic       line_end;

  modport source (
    output valid, output byte_out, output field_kind, output facility,
    output severity, output pri_valid, output modern_format, output error_code,
    output line_end, input ready
  );
  modport sink (
    input valid, input byte_out, input field_kind, input facility,
    input severity, input pri_valid, input modern_format, input error_code,
    input line_end, output ready
  );
endinterface
`default_nettype wire

### hw/rtl/shtok_in_stage.sv
// input register stage of the tokenizer
`default_nettype none
module shtok_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  shtok_in_if.sink              in_i,
  input  wire logic             advance_i,
  output logic                  stage_valid_o,
  output shtok_pkg::stage_t     stage_o
);

  logic               valid_q;
  shtok_pkg::stage_t  data_q;

  // stage frees up when empty or when its item moves on
  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q.data_byte <= in_i.data_byte;
      data_q.last_byte <= in_i.last_byte;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = data_q;

endmodule
`default_nettype wire

### hw/rtl/shtok_step.sv
// per-byte parse step: next parser state and result item
`default_nettype none
module shtok_step (
  input  wire shtok_pkg::state_t  state_i,
  input  wire shtok_pkg::stage_t  item_i,
  output shtok_pkg::state_t   state_o,
  output shtok_pkg::result_t  result_o
);

  shtok_pkg::state_t nx;
  logic [7:0]  b;
  logic        is_digit;
  logic [10:0] pri_v;
  logic [2:0]  tc_inc;
  logic [2:0]  tc_min;
  logic [3:0]  kind;
  logic        hdr_done;
  logic        pv;

  assign b        = item_i.data_byte;
  assign is_digit = (b >= shtok_pkg::ChZero) && (b <= shtok_pkg::ChNine);
  assign pri_v    = ({3'd0, state_i.pri_accum} << 3) + ({3'd0, state_i.pri_accum} << 1)
                    + {7'd0, b[3:0]};
  assign tc_inc   = state_i.token_count + 3'd1;
  assign tc_min   = (state_i.token_count > shtok_pkg::KindClamp) ? shtok_pkg::KindClamp
                                                                 : state_i.token_count;

  always_comb begin
    nx   = state_i;
    kind = shtok_pkg::K_MSG;
    unique case (state_i.phase)
      shtok_pkg::PH_LT: begin
        kind = shtok_pkg::K_PRI;
        if (b == shtok_pkg::ChLt) begin
          nx.phase = shtok_pkg::PH_PRI;
        end else begin
          if (state_i.sticky_error == shtok_pkg::ERR_NONE) nx.sticky_error = shtok_pkg::ERR_NO_LT;
          nx.phase = shtok_pkg::PH_ERR;
        end
      end
      shtok_pkg::PH_PRI: begin
        kind = shtok_pkg::K_PRI;
        if (is_digit) begin
          if (state_i.pri_digits >= shtok_pkg::PriDigMax || pri_v > shtok_pkg::PriMax) begin
            if (state_i.sticky_error == shtok_pkg::ERR_NONE) begin
              nx.sticky_error = shtok_pkg::ERR_BAD_PRI;
            end
            nx.phase = shtok_pkg::PH_ERR;
          end else begin
            nx.pri_accum  = pri_v[7:0];
            nx.pri_digits = state_i.pri_digits + 2'd1;
          end
        end else if (b == shtok_pkg::ChGt && state_i.pri_digits != 2'd0) begin
          nx.held_priority = state_i.pri_accum;
          nx.phase         = shtok_pkg::PH_VER;
        end else begin
          if (state_i.sticky_error == shtok_pkg::ERR_NONE) begin
            nx.sticky_error = shtok_pkg::ERR_BAD_PRI;
          end
          nx.phase = shtok_pkg::PH_ERR;
        end
      end
      shtok_pkg::PH_VER: begin
        if (b == shtok_pkg::ChOne) begin
          nx.format_flag = 1'b1;
          kind           = shtok_pkg::K_VER;
          nx.phase       = shtok_pkg::PH_VERTAIL;
        end else if (b == shtok_pkg::ChSpace) begin
          nx.phase = shtok_pkg::PH_MSG;
        end else begin
          kind           = shtok_pkg::K_TS;
          nx.token_count = 3'd0;
          nx.phase       = shtok_pkg::PH_TS;
        end
      end
      shtok_pkg::PH_VERTAIL: begin
        if (b == shtok_pkg::ChSpace) begin
          kind           = shtok_pkg::K_SEP;
          nx.token_count = 3'd0;
          nx.phase       = shtok_pkg::PH_HDR;
        end else begin
          kind = shtok_pkg::K_VER;
        end
      end
      shtok_pkg::PH_HDR: begin
        if (b == shtok_pkg::ChSpace) begin
          kind           = shtok_pkg::K_SEP;
          nx.token_count = tc_inc;
          if (tc_inc >= shtok_pkg::HdrTokens) nx.phase = shtok_pkg::PH_SDSTART;
        end else begin
          kind = 4'(shtok_pkg::K_TS) + {1'b0, tc_min};
        end
      end
      shtok_pkg::PH_SDSTART: begin
        kind = shtok_pkg::K_SD;
        if (b == shtok_pkg::ChLbr) begin
          nx.inside_sd_element = 1'b1;
          nx.escape_seen       = 1'b0;
          nx.phase             = shtok_pkg::PH_SD;
        end else begin
          nx.phase = shtok_pkg::PH_SDAFTER;
        end
      end
      shtok_pkg::PH_SD: begin
        if (state_i.inside_sd_element) begin
          kind = shtok_pkg::K_SD;
          if (state_i.escape_seen) begin
            nx.escape_seen = 1'b0;
          end else if (b == shtok_pkg::ChBslash) begin
            nx.escape_seen = 1'b1;
          end else if (b == shtok_pkg::ChRbr) begin
            nx.inside_sd_element = 1'b0;
          end
        end else if (b == shtok_pkg::ChLbr) begin
          kind                 = shtok_pkg::K_SD;
          nx.inside_sd_element = 1'b1;
          nx.escape_seen       = 1'b0;
        end else begin
          kind     = (b == shtok_pkg::ChSpace) ? shtok_pkg::K_SEP : shtok_pkg::K_MSG;
          nx.phase = shtok_pkg::PH_MSG;
        end
      end
      shtok_pkg::PH_SDAFTER: begin
        kind     = (b == shtok_pkg::ChSpace) ? shtok_pkg::K_SEP : shtok_pkg::K_MSG;
        nx.phase = shtok_pkg::PH_MSG;
      end
      shtok_pkg::PH_TS: begin
        if (b == shtok_pkg::ChSpace) begin
          kind           = shtok_pkg::K_SEP;
          nx.token_count = tc_inc;
          if (tc_inc >= shtok_pkg::TsTokens) nx.phase = shtok_pkg::PH_HOST;
        end else begin
          kind = shtok_pkg::K_TS;
        end
      end
      shtok_pkg::PH_HOST: begin
        if (b == shtok_pkg::ChSpace) begin
          kind     = shtok_pkg::K_SEP;
          nx.phase = shtok_pkg::PH_MSG;
        end else begin
          kind = shtok_pkg::K_HOST;
        end
      end
      shtok_pkg::PH_MSG: begin
        kind = shtok_pkg::K_MSG;
      end
      default: begin
        kind     = shtok_pkg::K_MSG;
        nx.phase = shtok_pkg::PH_ERR;
      end
    endcase

    // header complete once sd closed or skipped, or message or host reached
    if (nx.phase == shtok_pkg::PH_SD) begin
      hdr_done = !nx.inside_sd_element;
    end else begin
      hdr_done = (nx.phase == shtok_pkg::PH_SDAFTER) || (nx.phase == shtok_pkg::PH_MSG) ||
                 (nx.phase == shtok_pkg::PH_HOST);
    end

    pv = (nx.phase >= shtok_pkg::PH_VER) && (nx.phase != shtok_pkg::PH_ERR);
    if (item_i.last_byte && nx.sticky_error == shtok_pkg::ERR_NONE && !hdr_done) begin
      nx.sticky_error = shtok_pkg::ERR_TRUNC;
    end
    if (nx.sticky_error != shtok_pkg::ERR_NONE) pv = 1'b0;

    result_o.byte_out      = b;
    result_o.field_kind    = kind;
    result_o.facility      = pv ? nx.held_priority[7:3] : 5'd0;
    result_o.severity      = pv ? nx.held_priority[2:0] : 3'd0;
    result_o.pri_valid     = pv;
    result_o.modern_format = nx.format_flag;
    result_o.error_code    = nx.sticky_error;
    result_o.line_end      = item_i.last_byte;

    state_o = item_i.last_byte ? shtok_pkg::StateReset : nx;
  end

endmodule
`default_nettype wire

### hw/rtl/syslog_header_tokenizer_core.sv
// top level of the streaming syslog header tokenizer
//
// usage: bytes of a syslog line enter on in_i (data_byte, last_byte) with a
// valid/ready handshake; each accepted item yields exactly one result item on
// out_o carrying the byte and its field tag, priority split into facility and
// severity, format flag, sticky error code and a copy of last_byte as line_end
// path: an accepted item is held in the input register and then moves to the
// result register once that register is empty or being drained
// throughput: one item per cycle while out_o.ready stays high; the only
// feedback is the parser state register, loaded along with the result register
// stall: when out_o.ready is low the result holds, the input register keeps
// its item and in_i.ready drops only once both registers are full
// reset: rst_ni clears both valid flags and returns the parser to waiting for
// the opening angle bracket; the parser also returns there after each
// result marked line_end
`default_nettype none
module syslog_header_tokenizer_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  shtok_in_if.sink   in_i,
  shtok_out_if.source out_o
);

  // pipeline control
  logic               advance;
  logic               stage_valid;
  shtok_pkg::stage_t  stage;

  // parser state and step outputs
  shtok_pkg::state_t  state_q;
  shtok_pkg::state_t  state_d;
  shtok_pkg::result_t step_res;

  // result register
  logic               res_valid_q;
  shtok_pkg::result_t res_q;

  // result register can take a new item when empty or being drained
  assign advance = !res_valid_q || out_o.ready;

  shtok_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  shtok_step u_step (
    .state_i  (state_q),
    .item_i   (stage),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // state moves only when the staged item is committed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shtok_pkg::StateReset;
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= stage_valid;
      if (stage_valid) begin
        state_q <= state_d;
      end
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk_i) begin
    if (advance && stage_valid) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.byte_out      = res_q.byte_out;
  assign out_o.field_kind    = res_q.field_kind;
  assign out_o.facility      = res_q.facility;
  assign out_o.severity      = res_q.severity;
  assign out_o.pri_valid     = res_q.pri_valid;
  assign out_o.modern_format = res_q.modern_format;
  assign out_o.error_code    = res_q.error_code;
  assign out_o.line_end      = res_q.line_end;

  // committing the last byte of a line puts the parser back to reset state
  a_line_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stage_valid && stage.last_byte |=> state_q == shtok_pkg::StateReset)
    else $error("parser state not cleared after end of line");

  // a sticky error inside a line always parks the parser in the error phase
  a_error_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.sticky_error != shtok_pkg::ERR_NONE |-> state_q.phase == shtok_pkg::PH_ERR)
    else $error("sticky error without error phase");

  // a valid priority on a result never comes with an error code
  a_pri_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.pri_valid |-> res_q.error_code == shtok_pkg::ERR_NONE)
    else $error("priority flagged valid alongside an error");

  // a committed result is always the one the handshake then delivers
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_o.ready |=> res_valid_q && $stable(res_q) && $stable(state_q))
    else $error("result or parser state changed during stall");

endmodule
`default_nettype wire
